>>> sv/sove_pkg.sv
package sove_pkg;

	// Default coordinate width and queue depth for the expander.
	localparam int COORD_BITS_DEF  = 16;
	localparam int QUEUE_DEPTH_DEF = 2;

	// A shape expands into at most this many pen commands.
	localparam int MAX_CMDS = 6;
	localparam int CNT_BITS = 3;

	// Star factors are signed fixed point with sixteen fraction bits.
	localparam int K_BITS    = 18;
	localparam int FRAC_BITS = 16;

	localparam logic signed [K_BITS-1:0] STAR_A_NEG = -18'sd38521;
	localparam logic signed [K_BITS-1:0] STAR_B_NEG = -18'sd53020;
	localparam logic signed [K_BITS-1:0] STAR_C_POS =  18'sd62328;
	localparam logic signed [K_BITS-1:0] STAR_D_POS =  18'sd20251;
	localparam logic signed [K_BITS-1:0] STAR_C_NEG = -18'sd62328;
	localparam logic signed [K_BITS-1:0] STAR_A_POS =  18'sd38521;

	typedef enum logic [3:0] {
		SHAPE_LINE      = 4'd0,
		SHAPE_CROSS     = 4'd1,
		SHAPE_BOX       = 4'd2,
		SHAPE_STAR      = 4'd3,
		SHAPE_TRIANGLE  = 4'd4,
		SHAPE_DIAMOND   = 4'd5,
		SHAPE_VEE       = 4'd6,
		SHAPE_PLUS      = 4'd7,
		SHAPE_HOURGLASS = 4'd8,
		SHAPE_ELLIPSE   = 4'd9
	} shape_t;

	typedef enum logic [1:0] {
		KIND_MOVE = 2'd0,
		KIND_LINE = 2'd1,
		KIND_BOX  = 2'd2
	} kind_t;

	// Width of one queued command list: count, commands, radii and color.
	function automatic int entry_bits(int cb);
		return CNT_BITS + MAX_CMDS * (2 + 2 * cb) + 2 * cb + 8;
	endfunction

endpackage

>>> sv/sove_ifs.sv
interface sove_in_if #(parameter int COORD_BITS = sove_pkg::COORD_BITS_DEF);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] first_x;
	logic signed [COORD_BITS-1:0] first_y;
	logic signed [COORD_BITS-1:0] second_x;
	logic signed [COORD_BITS-1:0] second_y;
	logic [3:0]                   shape_code;
	logic [7:0]                   pen_color;

	modport source (output valid, first_x, first_y, second_x, second_y, shape_code, pen_color,
		input ready);
	modport sink (input valid, first_x, first_y, second_x, second_y, shape_code, pen_color,
		output ready);
endinterface

interface sove_out_if #(parameter int COORD_BITS = sove_pkg::COORD_BITS_DEF);
	logic                         valid;
	logic                         ready;
	logic [1:0]                   command_kind;
	logic signed [COORD_BITS-1:0] point_x;
	logic signed [COORD_BITS-1:0] point_y;
	logic [COORD_BITS-1:0]        corner_radius_x;
	logic [COORD_BITS-1:0]        corner_radius_y;
	logic [7:0]                   color_out;
	logic                         last_command;

	modport source (output valid, command_kind, point_x, point_y, corner_radius_x,
		corner_radius_y, color_out, last_command, input ready);
	modport sink (input valid, command_kind, point_x, point_y, corner_radius_x,
		corner_radius_y, color_out, last_command, output ready);
endinterface

>>> sv/sove_front.sv
module sove_front #(
	parameter int COORD_BITS = sove_pkg::COORD_BITS_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	sove_in_if.sink                                       shape,
	output logic                                          push_valid,
	input  logic                                          push_ready,
	output logic [sove_pkg::entry_bits(COORD_BITS)-1:0]   push_data
);
	import sove_pkg::*;

	localparam int W = COORD_BITS;

	typedef struct packed {
		kind_t               kind;
		logic signed [W-1:0] x;
		logic signed [W-1:0] y;
	} cmd_t;

	typedef struct packed {
		logic [CNT_BITS-1:0]   count;
		cmd_t [MAX_CMDS-1:0]   cmds;
		logic [W-1:0]          rx;
		logic [W-1:0]          ry;
		logic [7:0]            color;
	} entry_t;

	function automatic logic signed [W+1:0] scale(input logic signed [W-1:0] h,
		input logic signed [K_BITS-1:0] k);
		logic signed [W+K_BITS-1:0] p;
		p = $signed({{K_BITS{h[W-1]}}, h}) * $signed({{W{k[K_BITS-1]}}, k});
		return p[FRAC_BITS+W+1:FRAC_BITS];
	endfunction

	function automatic logic signed [W-1:0] add_sat(input logic signed [W-1:0] a,
		input logic signed [W+1:0] b);
		logic signed [W+1:0] s;
		s = {{2{a[W-1]}}, a} + b;
		if (s[W+1:W-1] == '0 || s[W+1:W-1] == '1) begin
			return s[W-1:0];
		end else if (s[W+1]) begin
			return {1'b1, {(W-1){1'b0}}};
		end else begin
			return {1'b0, {(W-1){1'b1}}};
		end
	endfunction

	function automatic cmd_t mk(input kind_t k, input logic signed [W-1:0] x,
		input logic signed [W-1:0] y);
		cmd_t c;
		c.kind = k;
		c.x    = x;
		c.y    = y;
		return c;
	endfunction

	// Stage one: registered corners with midpoints, half extents and extents.
	logic signed [W:0]   sum_x, sum_y, dif_x, dif_y, abs_x, abs_y;
	logic                v_s1, accept, s1_move, s1_free;
	logic signed [W-1:0] x1_s1, y1_s1, x2_s1, y2_s1, mx_s1, my_s1, hx_s1, hy_s1;
	logic [W-1:0]        rx_s1, ry_s1;
	shape_t              shape_s1;
	logic [7:0]          color_s1;

	// Stage two: star offsets scaled by the fixed-point factors.
	logic                v_s2, s2_move, s2_free;
	logic signed [W-1:0] x1_s2, y1_s2, x2_s2, y2_s2, mx_s2, my_s2, hy_s2;
	logic [W-1:0]        rx_s2, ry_s2;
	shape_t              shape_s2;
	logic [7:0]          color_s2;
	logic signed [W+1:0] an_s2, cp_s2, cn_s2, ap_s2, bn_s2, dp_s2;

	logic signed [W-1:0] tx, ty, y_low, y_high, x_an, x_cp, x_cn, x_ap;
	entry_t              ent;

	always_comb begin
		sum_x = {shape.first_x[W-1], shape.first_x} + {shape.second_x[W-1], shape.second_x};
		sum_y = {shape.first_y[W-1], shape.first_y} + {shape.second_y[W-1], shape.second_y};
		dif_x = {shape.second_x[W-1], shape.second_x} - {shape.first_x[W-1], shape.first_x};
		dif_y = {shape.second_y[W-1], shape.second_y} - {shape.first_y[W-1], shape.first_y};
		abs_x = dif_x[W] ? -dif_x : dif_x;
		abs_y = dif_y[W] ? -dif_y : dif_y;
	end

	assign s2_move     = v_s2 && (ent.count == '0 || push_ready);
	assign s2_free     = !v_s2 || s2_move;
	assign s1_move     = v_s1 && s2_free;
	assign s1_free     = !v_s1 || s1_move;
	assign shape.ready = s1_free;
	assign accept      = shape.valid && s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (s1_move) begin
				v_s1 <= 1'b0;
			end
			if (s1_move) begin
				v_s2 <= 1'b1;
			end else if (s2_move) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x1_s1    <= shape.first_x;
			y1_s1    <= shape.first_y;
			x2_s1    <= shape.second_x;
			y2_s1    <= shape.second_y;
			mx_s1    <= sum_x[W:1];
			my_s1    <= sum_y[W:1];
			hx_s1    <= dif_x[W:1];
			hy_s1    <= dif_y[W:1];
			rx_s1    <= abs_x[W-1:0];
			ry_s1    <= abs_y[W-1:0];
			shape_s1 <= shape_t'(shape.shape_code);
			color_s1 <= shape.pen_color;
		end
		if (s1_move) begin
			x1_s2    <= x1_s1;
			y1_s2    <= y1_s1;
			x2_s2    <= x2_s1;
			y2_s2    <= y2_s1;
			mx_s2    <= mx_s1;
			my_s2    <= my_s1;
			hy_s2    <= hy_s1;
			rx_s2    <= rx_s1;
			ry_s2    <= ry_s1;
			shape_s2 <= shape_s1;
			color_s2 <= color_s1;
			an_s2    <= scale(hx_s1, STAR_A_NEG);
			cp_s2    <= scale(hx_s1, STAR_C_POS);
			cn_s2    <= scale(hx_s1, STAR_C_NEG);
			ap_s2    <= scale(hx_s1, STAR_A_POS);
			bn_s2    <= scale(hy_s1, STAR_B_NEG);
			dp_s2    <= scale(hy_s1, STAR_D_POS);
		end
	end

	always_comb begin
		tx     = mx_s2;
		ty     = add_sat(my_s2, {{2{hy_s2[W-1]}}, hy_s2});
		y_low  = add_sat(my_s2, bn_s2);
		y_high = add_sat(my_s2, dp_s2);
		x_an   = add_sat(mx_s2, an_s2);
		x_cp   = add_sat(mx_s2, cp_s2);
		x_cn   = add_sat(mx_s2, cn_s2);
		x_ap   = add_sat(mx_s2, ap_s2);
	end

	// The shape code selects the command list; unknown codes give an empty list.
	always_comb begin
		ent       = '0;
		ent.color = color_s2;
		unique case (shape_s2)
			SHAPE_LINE: begin
				ent.count   = CNT_BITS'(2);
				ent.cmds[0] = mk(KIND_MOVE, x1_s2, y1_s2);
				ent.cmds[1] = mk(KIND_LINE, x2_s2, y2_s2);
			end
			SHAPE_CROSS: begin
				ent.count   = CNT_BITS'(4);
				ent.cmds[0] = mk(KIND_MOVE, x1_s2, y1_s2);
				ent.cmds[1] = mk(KIND_LINE, x2_s2, y2_s2);
				ent.cmds[2] = mk(KIND_MOVE, x1_s2, y2_s2);
				ent.cmds[3] = mk(KIND_LINE, x2_s2, y1_s2);
			end
			SHAPE_BOX: begin
				ent.count   = CNT_BITS'(2);
				ent.cmds[0] = mk(KIND_MOVE, x1_s2, y1_s2);
				ent.cmds[1] = mk(KIND_BOX, x2_s2, y2_s2);
			end
			SHAPE_ELLIPSE: begin
				ent.count   = CNT_BITS'(2);
				ent.cmds[0] = mk(KIND_MOVE, x1_s2, y1_s2);
				ent.cmds[1] = mk(KIND_BOX, x2_s2, y2_s2);
				ent.rx      = rx_s2;
				ent.ry      = ry_s2;
			end
			SHAPE_TRIANGLE: begin
				ent.count   = CNT_BITS'(4);
				ent.cmds[0] = mk(KIND_MOVE, x1_s2, y2_s2);
				ent.cmds[1] = mk(KIND_LINE, mx_s2, y1_s2);
				ent.cmds[2] = mk(KIND_LINE, x2_s2, y2_s2);
				ent.cmds[3] = mk(KIND_LINE, x1_s2, y2_s2);
			end
			SHAPE_DIAMOND: begin
				ent.count   = CNT_BITS'(5);
				ent.cmds[0] = mk(KIND_MOVE, mx_s2, y1_s2);
				ent.cmds[1] = mk(KIND_LINE, x1_s2, my_s2);
				ent.cmds[2] = mk(KIND_LINE, mx_s2, y2_s2);
				ent.cmds[3] = mk(KIND_LINE, x2_s2, my_s2);
				ent.cmds[4] = mk(KIND_LINE, mx_s2, y1_s2);
			end
			SHAPE_VEE: begin
				ent.count   = CNT_BITS'(3);
				ent.cmds[0] = mk(KIND_MOVE, x1_s2, y1_s2);
				ent.cmds[1] = mk(KIND_LINE, mx_s2, y2_s2);
				ent.cmds[2] = mk(KIND_LINE, x2_s2, y1_s2);
			end
			SHAPE_PLUS: begin
				ent.count   = CNT_BITS'(4);
				ent.cmds[0] = mk(KIND_MOVE, mx_s2, y1_s2);
				ent.cmds[1] = mk(KIND_LINE, mx_s2, y2_s2);
				ent.cmds[2] = mk(KIND_MOVE, x1_s2, my_s2);
				ent.cmds[3] = mk(KIND_LINE, x2_s2, my_s2);
			end
			SHAPE_HOURGLASS: begin
				ent.count   = CNT_BITS'(5);
				ent.cmds[0] = mk(KIND_MOVE, x1_s2, y1_s2);
				ent.cmds[1] = mk(KIND_LINE, x2_s2, y2_s2);
				ent.cmds[2] = mk(KIND_LINE, x1_s2, y2_s2);
				ent.cmds[3] = mk(KIND_LINE, x2_s2, y1_s2);
				ent.cmds[4] = mk(KIND_LINE, x1_s2, y1_s2);
			end
			SHAPE_STAR: begin
				ent.count   = CNT_BITS'(6);
				ent.cmds[0] = mk(KIND_MOVE, tx, ty);
				ent.cmds[1] = mk(KIND_LINE, x_an, y_low);
				ent.cmds[2] = mk(KIND_LINE, x_cp, y_high);
				ent.cmds[3] = mk(KIND_LINE, x_cn, y_high);
				ent.cmds[4] = mk(KIND_LINE, x_ap, y_low);
				ent.cmds[5] = mk(KIND_LINE, tx, ty);
			end
			default: begin
				ent.count = '0;
			end
		endcase
	end

	assign push_valid = v_s2 && ent.count != '0;
	assign push_data  = ent;

endmodule

>>> sv/sove_queue.sv
module sove_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = sove_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);
	// DEPTH is a power of two, at least two.
	localparam int PW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [PW:0]      cnt_q;
	logic             do_push, do_pop;

	assign push_ready = cnt_q != (PW+1)'(DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> sv/sove_back.sv
module sove_back #(
	parameter int COORD_BITS = sove_pkg::COORD_BITS_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          pop_valid,
	output logic                                          pop_ready,
	input  logic [sove_pkg::entry_bits(COORD_BITS)-1:0]   pop_data,
	sove_out_if.source                                    cmd
);
	import sove_pkg::*;

	localparam int W = COORD_BITS;

	typedef struct packed {
		kind_t               kind;
		logic signed [W-1:0] x;
		logic signed [W-1:0] y;
	} cmd_t;

	typedef struct packed {
		logic [CNT_BITS-1:0]   count;
		cmd_t [MAX_CMDS-1:0]   cmds;
		logic [W-1:0]          rx;
		logic [W-1:0]          ry;
		logic [7:0]            color;
	} entry_t;

	entry_t              head;
	cmd_t                cur;
	logic [CNT_BITS-1:0] idx_q;
	logic                load, last;
	logic                valid_q, last_q;
	kind_t               kind_q;
	logic signed [W-1:0] x_q, y_q;
	logic [W-1:0]        rx_q, ry_q;
	logic [7:0]          color_q;

	assign head      = entry_t'(pop_data);
	assign cur       = head.cmds[idx_q];
	assign last      = idx_q == head.count - CNT_BITS'(1);
	assign load      = pop_valid && (!valid_q || cmd.ready);
	assign pop_ready = load && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= last ? '0 : idx_q + CNT_BITS'(1);
			end else if (cmd.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q  <= cur.kind;
			x_q     <= cur.x;
			y_q     <= cur.y;
			rx_q    <= (cur.kind == KIND_BOX) ? head.rx : '0;
			ry_q    <= (cur.kind == KIND_BOX) ? head.ry : '0;
			color_q <= head.color;
			last_q  <= last;
		end
	end

	assign cmd.valid           = valid_q;
	assign cmd.command_kind    = kind_q;
	assign cmd.point_x         = x_q;
	assign cmd.point_y         = y_q;
	assign cmd.corner_radius_x = rx_q;
	assign cmd.corner_radius_y = ry_q;
	assign cmd.color_out       = color_q;
	assign cmd.last_command    = last_q;

endmodule

>>> sv/shape_outline_vector_expander.sv
// Channel  Modport   Moves one word of
// -------  --------  -----------------------------------------------------------
// shape    sink      two corners, shape code and pen color (one shape)
// cmd      source    one pen command: kind, point, corner radii, color, last flag
//
// A shape word is taken every cycle while the command queue has room. The first
// command of a shape is offered on cmd from the output register after passing
// the two front stages and one queue slot. Commands then leave one per cycle
// while cmd is ready, and a shape gives 2 to 6 commands. The output register
// sets the sustained figure of one command a cycle.
// Reset clears all valid bits and the queue pointers; no clearing pass is needed.
// A stall on cmd fills the queue and then drops shape.ready; shapes with an
// unknown code are dropped in the front and produce no command.
module shape_outline_vector_expander #(
	parameter int COORD_BITS  = sove_pkg::COORD_BITS_DEF,
	parameter int QUEUE_DEPTH = sove_pkg::QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	sove_in_if.sink    shape,
	sove_out_if.source cmd
);
	import sove_pkg::*;

	localparam int EB = entry_bits(COORD_BITS);

	// The front registers each shape, works out midpoints, half extents and the
	// scaled star offsets, and expands the shape into a full command list, which is
	// one queue entry; the back walks it one command a cycle while cmd is ready.
	logic          push_valid, push_ready, pop_valid, pop_ready;
	logic [EB-1:0] push_data, pop_data;

	sove_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.shape      (shape),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	// The queue decouples the two halves, so the front keeps taking shapes while
	// the back is still emitting the commands of an earlier one.
	sove_queue #(.WIDTH(EB), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// The back frees a queue entry in the cycle its last command is loaded into
	// the output register, so the next shape follows without a gap.
	sove_back #(.COORD_BITS(COORD_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.cmd       (cmd)
	);

endmodule

>>> sv/sove_checker.sv
module sove_checker #(
	parameter int COORD_BITS = sove_pkg::COORD_BITS_DEF
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  cmd_valid,
	input logic                  cmd_ready,
	input logic [1:0]            cmd_kind,
	input logic [COORD_BITS-1:0] cmd_x,
	input logic [COORD_BITS-1:0] cmd_y,
	input logic [COORD_BITS-1:0] cmd_rx,
	input logic [COORD_BITS-1:0] cmd_ry,
	input logic [7:0]            cmd_color,
	input logic                  cmd_last
);
	import sove_pkg::*;

	// Set while the next command taken must open a new shape.
	logic after_last_q;
	logic taken;

	assign taken = cmd_valid && cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			after_last_q <= 1'b1;
		end else if (taken) begin
			after_last_q <= cmd_last;
		end
	end

	assert property (@(posedge clk) !arst_n |-> !cmd_valid)
		else $error("command valid during reset");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_ready |=> cmd_valid
			&& $stable({cmd_kind, cmd_x, cmd_y, cmd_rx, cmd_ry, cmd_color, cmd_last}))
		else $error("stalled command changed");

	assert property (@(posedge clk) disable iff (!arst_n)
		taken && after_last_q |-> cmd_kind == KIND_MOVE)
		else $error("shape does not open with a move");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_kind == KIND_MOVE |-> !cmd_last)
		else $error("shape ends with a move");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && (cmd_rx != '0 || cmd_ry != '0) |-> cmd_kind == KIND_BOX)
		else $error("corner radius on a command that is not a box");

endmodule

bind shape_outline_vector_expander sove_checker #(.COORD_BITS(COORD_BITS)) u_sove_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd.valid),
	.cmd_ready (cmd.ready),
	.cmd_kind  (cmd.command_kind),
	.cmd_x     (cmd.point_x),
	.cmd_y     (cmd.point_y),
	.cmd_rx    (cmd.corner_radius_x),
	.cmd_ry    (cmd.corner_radius_y),
	.cmd_color (cmd.color_out),
	.cmd_last  (cmd.last_command)
);
